// ===== hw/rtl/sdx_pkg.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder package
// Item types, character constants and the letter group classification.
// ----------------------------------------------------------------------------
package sdx_pkg;

   typedef struct packed {
      logic [7:0] character;
      logic       no_char;
      logic       word_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] code_char;
      logic       code_last;
   } rsp_item_type;

   typedef logic [2:0] group_type;

   localparam group_type GRP_NONE = 3'd0;
   localparam group_type GRP_LABIAL = 3'd1;
   localparam group_type GRP_GUTTURAL = 3'd2;
   localparam group_type GRP_DENTAL = 3'd3;
   localparam group_type GRP_LATERAL = 3'd4;
   localparam group_type GRP_NASAL = 3'd5;
   localparam group_type GRP_RHOTIC = 3'd6;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_H = 8'h68;
   localparam logic [7:0] CHAR_W = 8'h77;
   localparam logic [7:0] CHAR_Y = 8'h79;

   localparam logic [4:0] CODE_LENGTH_RESET = 5'd4;

   // Maps a lowercase consonant to its code group; anything else has none.
   function automatic group_type group_of(input logic [7:0] c);
      group_type g;
      unique case (c)
         8'h62, 8'h66, 8'h70, 8'h76: g = GRP_LABIAL;
         8'h63, 8'h67, 8'h6A, 8'h6B,
         8'h71, 8'h73, 8'h78, 8'h7A: g = GRP_GUTTURAL;
         8'h64, 8'h74: g = GRP_DENTAL;
         8'h6C: g = GRP_LATERAL;
         8'h6D, 8'h6E: g = GRP_NASAL;
         8'h72: g = GRP_RHOTIC;
         default: g = GRP_NONE;
      endcase
      return g;
   endfunction

endpackage

// ===== hw/rtl/sdx_code_buffer.sv =====
// ----------------------------------------------------------------------------
// Soundex code buffer
// Two banks of code characters, one written by the word builder and the
// other read by the emitter, with a registered read port.
// ----------------------------------------------------------------------------
module sdx_code_buffer #(
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   localparam int Depth = 2 ** ADDR_W;

   logic [7:0] mem [Depth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sdx_word_builder.sv =====
// ----------------------------------------------------------------------------
// Soundex word builder
// Registers each input item, classifies its character and stores the code
// characters of the current word into the builder's bank of the buffer.
// ----------------------------------------------------------------------------
module sdx_word_builder #(
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  sdx_pkg::req_item_type                    req_item,
   output logic                                     wr_en,
   output logic [(MAX_CODE_LEN > 1 ? $clog2(MAX_CODE_LEN) : 1):0] wr_addr,
   output logic [7:0]                               wr_data,
   output logic                                     done_valid,
   input  logic                                     done_ready,
   output logic [$clog2(MAX_CODE_LEN + 1)-1:0]      done_count,
   output logic                                     done_bank
);

   localparam int IdxW = MAX_CODE_LEN > 1 ? $clog2(MAX_CODE_LEN) : 1;
   localparam int CntW = $clog2(MAX_CODE_LEN + 1);
   localparam logic [CntW-1:0] MaxLen = CntW'(MAX_CODE_LEN);

   logic                   in_valid_ff, in_valid_in;
   sdx_pkg::req_item_type  in_item_ff;
   logic [CntW-1:0]        count_ff, count_in;
   sdx_pkg::group_type     prev_ff, prev_in;
   logic                   start_ff, start_in;
   logic                   bank_ff, bank_in;

   logic                   advance;
   logic                   store_en;
   logic [7:0]             store_val;
   logic                   ignored;
   sdx_pkg::group_type     grp;
   logic [CntW-1:0]        count_next;

   assign done_valid = in_valid_ff && in_item_ff.word_end;
   assign advance = in_valid_ff && (!in_item_ff.word_end || done_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   assign grp = sdx_pkg::group_of(in_item_ff.character);
   assign ignored = (in_item_ff.character == sdx_pkg::CHAR_H) ||
                    (in_item_ff.character == sdx_pkg::CHAR_W) ||
                    (in_item_ff.character == sdx_pkg::CHAR_Y);

   always_comb begin
      store_en = 1'b0;
      store_val = in_item_ff.character;
      prev_in = prev_ff;
      start_in = start_ff;
      if (advance && !in_item_ff.no_char) begin
         if (start_ff) begin
            store_en = 1'b1;
            prev_in = grp;
            start_in = 1'b0;
         end else if (!ignored) begin
            if (grp != sdx_pkg::GRP_NONE && grp != prev_ff) begin
               store_en = 1'b1;
               store_val = sdx_pkg::CHAR_ZERO + {5'b0, grp};
            end
            prev_in = grp;
         end
      end
      wr_en = store_en && (count_ff < MaxLen);
      count_next = count_ff + {{(CntW - 1){1'b0}}, wr_en};
      count_in = count_next;
      bank_in = bank_ff;
      if (advance && in_item_ff.word_end) begin
         count_in = '0;
         prev_in = sdx_pkg::GRP_NONE;
         start_in = 1'b1;
         bank_in = !bank_ff;
      end
   end

   assign wr_addr = {bank_ff, count_ff[IdxW-1:0]};
   assign wr_data = store_val;
   assign done_count = count_next;
   assign done_bank = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff <= '0;
         prev_ff <= sdx_pkg::GRP_NONE;
         start_ff <= 1'b1;
         bank_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff <= count_in;
         prev_ff <= prev_in;
         start_ff <= start_in;
         bank_ff <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // A fresh word has stored nothing and carries no group.
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (count_ff == '0) && (prev_ff == sdx_pkg::GRP_NONE))
      else $error("word start with stale state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxLen)
      else $error("code count beyond buffer depth");

   // Closing a word hands the buffer bank over to the emitter.
   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (done_valid && done_ready) |=> (bank_ff != $past(bank_ff)) && start_ff)
      else $error("word close without bank swap");

endmodule

// ===== hw/rtl/sdx_emitter.sv =====
// ----------------------------------------------------------------------------
// Soundex code emitter
// Reads a finished word's code from the buffer one character per cycle
// while the result register is free or being taken, pads it with zeros to
// the configured length and drives the result register.
// ----------------------------------------------------------------------------
module sdx_emitter #(
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [4:0]                               code_length,
   input  logic                                     done_valid,
   output logic                                     done_ready,
   input  logic [$clog2(MAX_CODE_LEN + 1)-1:0]      done_count,
   input  logic                                     done_bank,
   output logic                                     rd_en,
   output logic [(MAX_CODE_LEN > 1 ? $clog2(MAX_CODE_LEN) : 1):0] rd_addr,
   input  logic [7:0]                               rd_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output sdx_pkg::rsp_item_type                    rsp_item
);

   localparam int IdxW = MAX_CODE_LEN > 1 ? $clog2(MAX_CODE_LEN) : 1;
   localparam int CntW = $clog2(MAX_CODE_LEN + 1);
   localparam logic [CntW-1:0] MaxLen = CntW'(MAX_CODE_LEN);
   localparam logic [CntW-1:0] OneLen = CntW'(1);

   logic                busy_ff, busy_in;
   logic                bank_ff;
   logic [CntW-1:0]     idx_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [CntW-1:0]     len_ff;
   logic                out_valid_ff, out_valid_in;
   logic                pad_ff;
   logic                last_ff;

   logic                load;
   logic                load_last;
   logic                take_word;
   logic [CntW-1:0]     len_eff;
   logic [CntW-1:0]     idx_next;

   assign done_ready = !busy_ff;
   assign take_word = done_valid && done_ready;
   assign load = busy_ff && (!out_valid_ff || rsp_ready);
   assign idx_next = idx_ff + OneLen;
   assign load_last = idx_next == len_ff;

   always_comb begin
      if (code_length == 5'd0) begin
         len_eff = OneLen;
      end else if (32'(code_length) > 32'(MAX_CODE_LEN)) begin
         len_eff = MaxLen;
      end else begin
         len_eff = CntW'(code_length);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (take_word) begin
         busy_in = 1'b1;
      end else if (load && load_last) begin
         busy_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rd_en = load;
   assign rd_addr = {bank_ff, idx_ff[IdxW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_word) begin
         bank_ff <= done_bank;
         idx_ff <= '0;
         cnt_ff <= done_count;
         len_ff <= len_eff;
      end else if (load) begin
         idx_ff <= idx_next;
      end
      if (load) begin
         pad_ff <= idx_ff >= cnt_ff;
         last_ff <= load_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item.code_char = pad_ff ? sdx_pkg::CHAR_ZERO : rd_data;
   assign rsp_item.code_last = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < len_ff) && (len_ff != '0) && (len_ff <= MaxLen))
      else $error("emit index outside code length");

   // The final character of a code ends the emission.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load && load_last) |=> !busy_ff && last_ff && out_valid_ff)
      else $error("emission not closed on last character");

   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      take_word |=> busy_ff && (idx_ff == '0))
      else $error("word taken without starting emission");

endmodule

// ===== hw/rtl/soundex_encoder_top.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder top level
// Builds a Soundex-style code from a word given one character per item and
// emits the code one character per item when the word ends.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   character, no_char, word_end
//   rsp_      out        rsp_valid / rsp_ready   code_char, code_last
//   csr_      in         csr_wr_en               code_length (5 bits)
//
// Each input item passes the input register and is classified in the next
// cycle, so characters are taken at one per cycle.
// A word's end gives code_length result items (clamped to 1..MAX_CODE_LEN),
// one per cycle from the emitter's read port; the next word is built into the
// other buffer bank meanwhile, and its end waits until the emitter is free.
// Reset is synchronous; it clears the word state and sets code_length to 4.
// A stalled result holds the emitter, and a held input register holds req_.
// ----------------------------------------------------------------------------
module soundex_encoder_top #(
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sdx_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sdx_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [4:0]            csr_wr_data
);

   localparam int IdxW = MAX_CODE_LEN > 1 ? $clog2(MAX_CODE_LEN) : 1;
   localparam int CntW = $clog2(MAX_CODE_LEN + 1);

   logic [4:0]      code_length_ff, code_length_in;
   logic            wr_en;
   logic [IdxW:0]   wr_addr;
   logic [7:0]      wr_data;
   logic            rd_en;
   logic [IdxW:0]   rd_addr;
   logic [7:0]      rd_data;
   logic            done_valid;
   logic            done_ready;
   logic [CntW-1:0] done_count;
   logic            done_bank;

   assign code_length_in = csr_wr_en ? csr_wr_data : code_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff <= sdx_pkg::CODE_LENGTH_RESET;
      end else begin
         code_length_ff <= code_length_in;
      end
   end

   sdx_word_builder #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_builder (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_count (done_count),
      .done_bank  (done_bank)
   );

   sdx_code_buffer #(
      .ADDR_W(IdxW + 1)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sdx_emitter #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_emitter (
      .clock       (clock),
      .reset       (reset),
      .code_length (code_length_ff),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_count  (done_count),
      .done_bank   (done_bank),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soundex encoder testbench
// Streams words into the encoder one character per item and predicts every
// code character it should emit, checking each result against the oldest
// prediction. Directed words cover the special characters, then the code
// length register is swept, then random words run under three idling mixes.
// ----------------------------------------------------------------------------
module tb;

   localparam int CODE_SLOTS = 16;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT = 50000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sdx_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sdx_pkg::rsp_item_type rsp_item;
   logic                  csr_wr_en = 1'b0;
   logic [4:0]            csr_wr_data = '0;

   // Encoder state as the testbench expects it.
   logic [4:0]            code_length_setting = sdx_pkg::CODE_LENGTH_RESET;
   logic [7:0]            word_chars [CODE_SLOTS];
   int unsigned           word_count = 0;
   sdx_pkg::group_type    last_group = sdx_pkg::GRP_NONE;
   logic                  word_start = 1'b1;
   sdx_pkg::rsp_item_type expected_codes [$];

   int unsigned  send_idle_pct = 31;
   int unsigned  rsp_idle_pct = 48;
   int unsigned  fault_count = 0;
   int unsigned  items_sent = 0;
   int unsigned  words_ended = 0;
   int unsigned  codes_checked = 0;
   int unsigned  length_settings = 0;

   soundex_encoder_top #(
      .MAX_CODE_LEN(CODE_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Run timed out with %0d code characters outstanding.", expected_codes.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic sdx_pkg::group_type letter_group(input logic [7:0] c);
      case (c)
         "b", "f", "p", "v": return sdx_pkg::GRP_LABIAL;
         "c", "g", "j", "k", "q", "s", "x", "z": return sdx_pkg::GRP_GUTTURAL;
         "d", "t": return sdx_pkg::GRP_DENTAL;
         "l": return sdx_pkg::GRP_LATERAL;
         "m", "n": return sdx_pkg::GRP_NASAL;
         "r": return sdx_pkg::GRP_RHOTIC;
         default: return sdx_pkg::GRP_NONE;
      endcase
   endfunction

   function automatic void keep_code_char(input logic [7:0] c);
      if (word_count < CODE_SLOTS) begin
         word_chars[word_count] = c;
         word_count++;
      end
   endfunction

   task automatic absorb_item(input sdx_pkg::req_item_type it);
      sdx_pkg::group_type    g;
      int unsigned           len;
      sdx_pkg::rsp_item_type want;
      if (!it.no_char) begin
         g = letter_group(it.character);
         if (word_start) begin
            keep_code_char(it.character);
            last_group = g;
            word_start = 1'b0;
         end else if (it.character != sdx_pkg::CHAR_H && it.character != sdx_pkg::CHAR_W
                      && it.character != sdx_pkg::CHAR_Y) begin
            if (g != sdx_pkg::GRP_NONE && g != last_group)
               keep_code_char(sdx_pkg::CHAR_ZERO + {5'b0, g});
            last_group = g;
         end
      end
      if (it.word_end) begin
         len = 32'(code_length_setting);
         if (len < 1) len = 1;
         if (len > CODE_SLOTS) len = CODE_SLOTS;
         for (int unsigned k = 0; k < len; k++) begin
            want.code_char = (k < word_count) ? word_chars[k] : sdx_pkg::CHAR_ZERO;
            want.code_last = (k + 1 == len);
            expected_codes.push_back(want);
         end
         word_count = 0;
         last_group = sdx_pkg::GRP_NONE;
         word_start = 1'b1;
         words_ended++;
      end
   endtask

   task automatic send_item(input logic [7:0] ch, input logic none, input logic last);
      sdx_pkg::req_item_type it;
      it.character = ch;
      it.no_char = none;
      it.word_end = last;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
      absorb_item(it);
      items_sent++;
   endtask

   task automatic send_word(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, i == s.len() - 1);
   endtask

   task automatic wait_for_codes();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_codes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_codes.size() != 0) begin
         $display("Gave up waiting for %0d code characters.", expected_codes.size());
         $display("*** FAILED ***");
         $finish;
      end
   endtask

   task automatic settle();
      wait_for_codes();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_code_length(input logic [4:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      code_length_setting = value;
      length_settings++;
   endtask

   task automatic send_random_word();
      int unsigned  kind;
      int unsigned  n;
      logic         end_empty;
      logic [7:0]   ch;
      kind = $urandom_range(99);
      if (kind < 70) begin
         n = $urandom_range(1, 7);
         end_empty = ($urandom_range(5) == 0);
         for (int unsigned i = 0; i < n; i++) begin
            ch = 8'h61 + 8'($urandom_range(25));
            if (i == 0 && $urandom_range(9) == 0) ch = ch - 8'h20;
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
            send_item(ch, 1'b0, !end_empty && i == n - 1);
         end
         if (end_empty) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
      end else if (kind < 88) begin
         n = $urandom_range(1, 6);
         for (int unsigned i = 0; i < n; i++)
            send_item(8'($urandom_range(255)), $urandom_range(4) == 0, i == n - 1);
      end else if (kind < 94) begin
         n = $urandom_range(17, 24);
         for (int unsigned i = 0; i < n; i++)
            send_item(8'h61 + 8'($urandom_range(25)), 1'b0, i == n - 1);
      end else begin
         repeat ($urandom_range(2)) send_item(8'($urandom_range(255)), 1'b1, 1'b0);
         send_item(8'($urandom_range(255)), 1'b1, 1'b1);
      end
   endtask

   // Runs at the reset code length of four.
   task automatic test_special_characters();
      send_word("robert");
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item("b", 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item("b", 1'b0, 1'b0);
      send_item("B", 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item("s", 1'b0, 1'b0);
      send_item("h", 1'b0, 1'b0);
      send_item(8'hA5, 1'b1, 1'b0);
      send_item("c", 1'b0, 1'b0);
      send_item("z", 1'b0, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);
      send_word("bab");
      settle();
   endtask

   task automatic test_code_length_register();
      logic [4:0] lengths [6] = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd9};
      foreach (lengths[i]) begin
         set_code_length(lengths[i]);
         if (lengths[i] >= 16) send_word("bcdlmrbcdlmrbcdlmrbcd");
         send_word("pup");
         settle();
      end
   endtask

   task automatic test_random_traffic(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned item_goal);
      int unsigned first_item;
      int unsigned words;
      send_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      if ($urandom_range(99) < 20) set_code_length(5'($urandom_range(31)));
      else set_code_length(5'($urandom_range(1, 8)));
      first_item = items_sent;
      words = 0;
      while (items_sent - first_item < item_goal) begin
         send_random_word();
         words++;
         if (words == 4 || $urandom_range(14) == 0) wait_for_codes();
      end
      settle();
   endtask

   always @(posedge clock) begin : code_checker
      sdx_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_codes.size() == 0) begin
            if (fault_count < 10)
               $display("Unexpected code character %h (last %b).",
                        rsp_item.code_char, rsp_item.code_last);
            fault_count++;
         end else begin
            want = expected_codes.pop_front();
            if (rsp_item.code_char !== want.code_char || rsp_item.code_last !== want.code_last)
            begin
               if (fault_count < 10)
                  $display("Code character %0d: expected %h (last %b), got %h (last %b).",
                           codes_checked, want.code_char, want.code_last,
                           rsp_item.code_char, rsp_item.code_last);
               fault_count++;
            end
            codes_checked++;
         end
      end
      rsp_ready <= (rsp_idle_pct == 0) || ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_special_characters();
      test_code_length_register();
      test_random_traffic(31, 48, 15);
      test_random_traffic(48, 31, 15);
      test_random_traffic(0, 0, 15);
      settle();
      $display("Sent %0d items forming %0d words and checked %0d code characters.",
               items_sent, words_ended, codes_checked);
      $display("The code length was set %0d times, and three idling mixes were run.",
               length_settings);
      if (fault_count == 0 && expected_codes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d faults found, %0d code characters never arrived.",
                  fault_count, expected_codes.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sdx_pkg.sv
hw/rtl/sdx_code_buffer.sv
hw/rtl/sdx_word_builder.sv
hw/rtl/sdx_emitter.sv
hw/rtl/soundex_encoder_top.sv
test/tb.sv
